// ===== design/b64e_pkg.sv =====
// Shared types, constants and the character table for the line-wrapped base64 encoder.
// No dependencies; every module of the block imports this package.
package b64e_pkg;

   localparam int QueueDepth = 4;
   localparam int QueuePtrW  = $clog2(QueueDepth);
   localparam int QueueCntW  = $clog2(QueueDepth + 1);

   localparam logic [7:0] NewlineChar = 8'h0A;
   localparam logic [7:0] PadChar     = 8'h3D;

   // Configuration register indexes
   localparam logic CsrWrapEnable    = 1'b0;
   localparam logic CsrGroupsPerLine = 1'b1;

   localparam logic [5:0] GroupsPerLineReset = 6'd16;

   // Character index of the optional newline within a group's output
   localparam logic [2:0] NewlineSlot = 3'd4;
   localparam logic [2:0] LastPadSlot = 3'd3;

   // One encoded group, handed from front to back
   typedef struct packed {
      logic [23:0] word;     // first byte in the top, zero-filled
      logic [1:0]  nbytes;   // real bytes in the group, 1 to 3
      logic        newline;  // append a newline after the four characters
      logic        last;     // group closes the message
   } group_cmd_type;

   // Map a six-bit value to its base64 alphabet character
   function automatic logic [7:0] b64_char(input logic [5:0] sextet);
      logic [7:0] ext;
      ext = {2'b00, sextet};
      if (sextet < 6'd26)       b64_char = 8'h41 + ext;
      else if (sextet < 6'd52)  b64_char = 8'h61 + (ext - 8'd26);
      else if (sextet < 6'd62)  b64_char = 8'h30 + (ext - 8'd52);
      else if (sextet == 6'd62) b64_char = 8'h2B;
      else                      b64_char = 8'h2F;
   endfunction

endpackage

// ===== design/b64e_front.sv =====
// Front end: accepts bytes, gathers groups of three and keeps the line count.
// Depends on b64e_pkg for the group command type.
module b64e_front (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   byte_valid,
   input  logic [7:0]             data_byte,
   input  logic                   last_byte,
   output logic                   byte_ready,
   input  logic                   wrap_enable,
   input  logic [5:0]             groups_per_line,
   input  logic                   queue_full,
   output logic                   push,
   output b64e_pkg::group_cmd_type cmd
);
   import b64e_pkg::*;

   logic [15:0] held_ff, held_in;
   logic [1:0]  bic_ff, bic_in;
   logic [5:0]  gil_ff, gil_in;

   logic        accept;
   logic [1:0]  count;
   logic [5:0]  gil_next;
   logic        line_full;

   assign byte_ready = !queue_full;
   assign accept     = byte_valid && byte_ready;
   assign count      = (bic_ff == 2'd3) ? 2'd3 : bic_ff + 2'd1;
   assign gil_next   = gil_ff + 6'd1;
   assign line_full  = (gil_next == groups_per_line);

   always_comb begin
      push        = accept && (count == 2'd3 || last_byte);
      cmd.nbytes  = count;
      cmd.last    = last_byte;
      case (count)
         2'd1:    cmd.word = {data_byte, 16'h0000};
         2'd2:    cmd.word = {held_ff[7:0], data_byte, 8'h00};
         default: cmd.word = {held_ff, data_byte};
      endcase
      if (line_full) cmd.newline = wrap_enable;
      else           cmd.newline = last_byte && wrap_enable && (gil_next != 6'd0);

      held_in = held_ff;
      bic_in  = bic_ff;
      gil_in  = gil_ff;
      if (accept) begin
         if (push) begin
            held_in = 16'h0000;
            bic_in  = 2'd0;
            gil_in  = (line_full || last_byte) ? 6'd0 : gil_next;
         end else begin
            held_in = {held_ff[7:0], data_byte};
            bic_in  = count;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         held_ff <= 16'h0000;
         bic_ff  <= 2'd0;
         gil_ff  <= 6'd0;
      end else begin
         held_ff <= held_in;
         bic_ff  <= bic_in;
         gil_ff  <= gil_in;
      end
   end

endmodule

// ===== design/b64e_queue.sv =====
// Short queue of group commands between front and back.
// Depends on b64e_pkg for the command type and the queue depth.
module b64e_queue (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   input  b64e_pkg::group_cmd_type push_cmd,
   output logic                   full,
   input  logic                   pop,
   output logic                   empty,
   output b64e_pkg::group_cmd_type head_cmd
);
   import b64e_pkg::*;

   group_cmd_type           slot_ff [QueueDepth];
   logic [QueuePtrW-1:0]    wr_ptr_ff, rd_ptr_ff;
   logic [QueueCntW-1:0]    cnt_ff, cnt_in;

   assign full     = (cnt_ff == QueueCntW'(QueueDepth));
   assign empty    = (cnt_ff == '0);
   assign head_cmd = slot_ff[rd_ptr_ff];

   always_comb begin
      cnt_in = cnt_ff;
      if (push && !pop)      cnt_in = cnt_ff + 1'b1;
      else if (pop && !push) cnt_in = cnt_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (push) slot_ff[wr_ptr_ff] <= push_cmd;
   end

   // Depth is a power of two, so the pointers wrap by overflow
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         if (push) wr_ptr_ff <= wr_ptr_ff + 1'b1;
         if (pop)  rd_ptr_ff <= rd_ptr_ff + 1'b1;
         cnt_ff <= cnt_in;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      !(push && full && !pop))
      else $error("group queue written while full");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      !(pop && empty))
      else $error("group queue read while empty");

endmodule

// ===== design/b64e_back.sv =====
// Back end: serialises each group command into characters, one per cycle while char_ready is high.
// Depends on b64e_pkg for the command type and the alphabet function.
module b64e_back (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   queue_empty,
   input  b64e_pkg::group_cmd_type head_cmd,
   output logic                   pop,
   output logic                   char_valid,
   input  logic                   char_ready,
   output logic [7:0]             out_char,
   output logic                   last_char
);
   import b64e_pkg::*;

   logic [2:0] idx_ff, idx_in;
   logic       valid_ff, valid_in;
   logic [7:0] char_ff, char_in;
   logic       last_ff, last_in;

   logic       load;
   logic       final_slot;
   logic [5:0] sextet;

   assign load       = !queue_empty && (!valid_ff || char_ready);
   assign final_slot = head_cmd.newline ? (idx_ff == NewlineSlot) : (idx_ff == LastPadSlot);
   assign pop        = load && final_slot;

   always_comb begin
      case (idx_ff[1:0])
         2'd0:    sextet = head_cmd.word[23:18];
         2'd1:    sextet = head_cmd.word[17:12];
         2'd2:    sextet = head_cmd.word[11:6];
         default: sextet = head_cmd.word[5:0];
      endcase

      if (idx_ff == NewlineSlot)                char_in = NewlineChar;
      else if (idx_ff > {1'b0, head_cmd.nbytes}) char_in = PadChar;
      else                                       char_in = b64_char(sextet);

      last_in  = load ? (final_slot && head_cmd.last) : last_ff;
      if (!load) char_in = char_ff;

      valid_in = load || (valid_ff && !char_ready);
      idx_in   = idx_ff;
      if (load) idx_in = final_slot ? 3'd0 : idx_ff + 3'd1;
   end

   always_ff @(posedge clock) begin
      char_ff <= char_in;
      last_ff <= last_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         idx_ff   <= 3'd0;
      end else begin
         valid_ff <= valid_in;
         idx_ff   <= idx_in;
      end
   end

   assign char_valid = valid_ff;
   assign out_char   = char_ff;
   assign last_char  = last_ff;

   a_idx_range: assert property (@(posedge clock) disable iff (reset)
      idx_ff <= NewlineSlot)
      else $error("character slot out of range");

   a_pop_restarts: assert property (@(posedge clock) disable iff (reset)
      pop |=> (idx_ff == 3'd0))
      else $error("slot counter not cleared after a group");

endmodule

// ===== design/base64_line_wrapped_encoder_top.sv =====
// Top level of the line-wrapped base64 encoder: configuration registers and wiring.
// Depends on b64e_pkg, b64e_front, b64e_queue and b64e_back.
//
// Bytes enter on the req_ stream, one beat per byte, with req_tlast on the final byte of
// a message; characters leave on the rsp_ stream, one beat per character, with rsp_tlast on
// the final character. Each group of three bytes yields four characters, plus a newline
// when a line fills (and a closing newline after a partial last line) while wrapping is
// enabled; a short last group is padded with '='. The front end takes a byte in every
// cycle while the four-entry group queue has room, so a burst of up to about a dozen bytes
// goes in at full speed; the sustained rate is set by the output port, which sends one
// character per cycle while rsp_tready is high: four or five characters per three bytes.
// The output register holds the current character while rsp_tready is low and is reloaded
// in the cycle it is taken, so characters leave back to back while rsp_tready stays high.
// Configuration is written through the csr_ port (index 0: wrap enable, index 1: groups
// per line, where 0 means 64) and must only be written while the block is idle; writes are
// always taken at once.
module base64_line_wrapped_encoder_top (
   input  logic       clock,
   input  logic       reset,
   // byte input
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,   // [7:0] data_byte
   input  logic       req_tlast,   // last_byte
   // character output
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,   // [7:0] out_char
   output logic       rsp_tlast,   // last_char
   // configuration writes
   input  logic       csr_valid,
   output logic       csr_ready,
   input  logic       csr_index,
   input  logic [5:0] csr_data
);
   import b64e_pkg::*;

   logic          wrap_ff;
   logic [5:0]    gpl_ff;

   logic          queue_full, queue_empty;
   logic          push, pop;
   group_cmd_type push_cmd, head_cmd;

   // Take every configuration beat at once
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         wrap_ff <= 1'b1;
         gpl_ff  <= GroupsPerLineReset;
      end else if (csr_valid) begin
         unique case (csr_index)
            CsrWrapEnable:    wrap_ff <= csr_data[0];
            CsrGroupsPerLine: gpl_ff  <= csr_data;
            default:          wrap_ff <= wrap_ff;
         endcase
      end
   end

   // Gather bytes into groups and decide where newlines go
   b64e_front u_front (
      .clock           (clock),
      .reset           (reset),
      .byte_valid      (req_tvalid),
      .data_byte       (req_tdata),
      .last_byte       (req_tlast),
      .byte_ready      (req_tready),
      .wrap_enable     (wrap_ff),
      .groups_per_line (gpl_ff),
      .queue_full      (queue_full),
      .push            (push),
      .cmd             (push_cmd)
   );

   // Hold finished groups so the two sides stall independently
   b64e_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_cmd (push_cmd),
      .full     (queue_full),
      .pop      (pop),
      .empty    (queue_empty),
      .head_cmd (head_cmd)
   );

   // Send the characters of the head group, one beat per cycle while rsp_tready is high
   b64e_back u_back (
      .clock       (clock),
      .reset       (reset),
      .queue_empty (queue_empty),
      .head_cmd    (head_cmd),
      .pop         (pop),
      .char_valid  (rsp_tvalid),
      .char_ready  (rsp_tready),
      .out_char    (rsp_tdata),
      .last_char   (rsp_tlast)
   );

endmodule

// ===== tb/tb.sv =====
// Self-checking testbench for the line-wrapped base64 encoder (base64_line_wrapped_encoder_top).
// Depends on b64e_pkg for the pad and newline characters and the register indexes.
`timescale 1ns / 1ps

module tb;
   import b64e_pkg::*;

   // Alphabet for the six-bit values, first character in the top byte
   localparam logic [511:0] Base64Alphabet =
      "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";
   localparam int SettleCycles = 16;    // drain time once nothing is outstanding
   localparam int StallLimit   = 1000;  // cycles without any beat before giving up
   localparam int RandomBytes  = 440;

   typedef struct packed {
      logic [7:0] data;
      logic       fin;
   } in_byte_type;

   typedef struct packed {
      logic [7:0] ch;
      logic       fin;
   } enc_char_type;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_tvalid = 1'b0;
   logic       req_tready;
   logic [7:0] req_tdata = 8'h00;   // [7:0] data_byte
   logic       req_tlast = 1'b0;    // last_byte
   logic       rsp_tvalid;
   logic       rsp_tready = 1'b0;
   logic [7:0] rsp_tdata;           // [7:0] out_char
   logic       rsp_tlast;           // last_char
   logic       csr_valid = 1'b0;
   logic       csr_ready;
   logic       csr_index = 1'b0;
   logic [5:0] csr_data = 6'd0;

   base64_line_wrapped_encoder_top dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // Bytes waiting to be driven, and characters the encoder still owes us
   in_byte_type  byte_backlog[$];
   enc_char_type encoded_chars[$];

   // Shadow of the encoder: configuration and group/line state
   logic       wrap_on     = 1'b1;
   logic [5:0] line_limit  = GroupsPerLineReset;
   logic [15:0] held_pair  = 16'h0000;
   logic [1:0] held_count  = 2'd0;
   logic [5:0] line_groups = 6'd0;

   int errors = 0;
   bit req_calm = 1'b0;   // phase with a sender that never pauses
   bit rsp_calm = 1'b0;   // phase with a receiver that never stalls

   // Pick the pause before the next beat: mostly none, sometimes short, now and then long.
   function automatic int draw_wait(input bit calm);
      int sel;
      sel = $urandom_range(0, 3);
      if (calm || sel < 2) draw_wait = 0;
      else if (sel == 2)   draw_wait = $urandom_range(1, 4);
      else                 draw_wait = $urandom_range(0, 18);
   endfunction

   // Work out the characters one accepted byte releases and queue them in order.
   task automatic encode_byte(input logic [7:0] b, input logic fin);
      enc_char_type burst[5];
      logic [23:0] word;
      logic [5:0] sextet;
      logic [1:0] nbytes;
      int         n;
      nbytes = held_count + 2'd1;
      n = 0;
      if (nbytes != 2'd3 && !fin) begin
         // hold the byte until the group fills or the message ends
         held_pair  = {held_pair[7:0], b};
         held_count = nbytes;
      end else begin
         case (nbytes)
            2'd1:    word = {b, 16'h0000};
            2'd2:    word = {held_pair[7:0], b, 8'h00};
            default: word = {held_pair, b};
         endcase
         for (int k = 0; k < 4; k++) begin
            sextet = word[18 - 6 * k +: 6];
            burst[n].ch  = (k <= nbytes) ? Base64Alphabet[8 * (63 - sextet) +: 8] : PadChar;
            burst[n].fin = 1'b0;
            n++;
         end
         // the line counter runs modulo 64 whether or not wrapping is on
         line_groups = line_groups + 6'd1;
         if (line_groups == line_limit) begin
            line_groups = 6'd0;
            if (wrap_on) begin
               burst[n] = '{ch: NewlineChar, fin: 1'b0};
               n++;
            end
         end else if (fin && wrap_on && line_groups != 6'd0) begin
            // close a partial last line
            burst[n] = '{ch: NewlineChar, fin: 1'b0};
            n++;
         end
         held_pair  = 16'h0000;
         held_count = 2'd0;
         if (fin) begin
            line_groups = 6'd0;
            burst[n - 1].fin = 1'b1;
         end
         for (int k = 0; k < n; k++) encoded_chars.push_back(burst[k]);
      end
   endtask

   // ---------------------------------------------------------------------------------------
   // Byte driver: present the next backlog byte after its drawn pause, hold while stalled,
   // and feed the shadow encoder on every accepted beat.
   // ---------------------------------------------------------------------------------------
   in_byte_type next_byte;
   int          req_gap = 0;

   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         req_gap    <= 0;
      end else begin
         if (req_tvalid && req_tready) encode_byte(req_tdata, req_tlast);
         if (!req_tvalid || req_tready) begin
            if (req_gap != 0) begin
               req_gap    <= req_gap - 1;
               req_tvalid <= 1'b0;
            end else if (byte_backlog.size() != 0) begin
               next_byte   = byte_backlog.pop_front();
               req_tvalid <= 1'b1;
               req_tdata  <= next_byte.data;
               req_tlast  <= next_byte.fin;
               req_gap    <= draw_wait(req_calm);
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // ---------------------------------------------------------------------------------------
   // Character monitor: compare every accepted beat with the oldest owed character, then
   // draw the stall before the next one. The stall only counts down while a character waits,
   // so it always lands on a real beat.
   // ---------------------------------------------------------------------------------------
   enc_char_type owed;
   int           rsp_wait = 0;
   int           rsp_stall;

   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
         rsp_wait   <= 0;
      end else begin
         rsp_stall = rsp_wait;
         if (rsp_tvalid && rsp_tready) begin
            if (encoded_chars.size() == 0) begin
               $display("%0t: unexpected character %02h (tlast %0d), none outstanding",
                        $time, rsp_tdata, rsp_tlast);
               errors++;
            end else begin
               owed = encoded_chars.pop_front();
               if (rsp_tdata !== owed.ch) begin
                  $display("%0t: out_char mismatch, expected %02h, got %02h",
                           $time, owed.ch, rsp_tdata);
                  errors++;
               end
               if (rsp_tlast !== owed.fin) begin
                  $display("%0t: last_char mismatch, expected %0d, got %0d",
                           $time, owed.fin, rsp_tlast);
                  errors++;
               end
            end
            rsp_stall = draw_wait(rsp_calm);
         end
         if (rsp_stall != 0) begin
            rsp_tready <= 1'b0;
            rsp_wait   <= rsp_tvalid ? rsp_stall - 1 : rsp_stall;
         end else begin
            rsp_tready <= 1'b1;
            rsp_wait   <= 0;
         end
      end
   end

   // ---------------------------------------------------------------------------------------
   // Watchdog: give up when no beat moves on any channel for too long.
   // ---------------------------------------------------------------------------------------
   int quiet_cycles = 0;

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)
          || (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles < StallLimit) begin
         quiet_cycles <= quiet_cycles + 1;
      end else begin
         $display("%0t: no progress, %0d bytes queued, %0d characters outstanding",
                  $time, byte_backlog.size(), encoded_chars.size());
         $display("TEST FAILED");
         $finish;
      end
   end

   // ---------------------------------------------------------------------------------------
   // Stimulus
   // ---------------------------------------------------------------------------------------

   // Write one register and mirror it into the shadow once the beat is taken.
   task automatic csr_write(input logic idx, input logic [5:0] value);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      if (idx == CsrWrapEnable) wrap_on = value[0];
      else                      line_limit = value;
      csr_valid <= 1'b0;
   endtask

   task automatic push_byte(input logic [7:0] data, input logic fin);
      byte_backlog.push_back('{data: data, fin: fin});
   endtask

   // Queue a run of random bytes, optionally closing the message on the final one.
   task automatic push_run(input int len, input bit close);
      for (int i = 0; i < len; i++)
         push_byte(8'($urandom_range(0, 255)), close && (i == len - 1));
   endtask

   // Wait until every byte is in and every owed character is out, then let the block drain.
   task automatic settle;
      do @(negedge clock);
      while (byte_backlog.size() != 0 || req_tvalid || encoded_chars.size() != 0);
      repeat (SettleCycles) @(posedge clock);
   endtask

   int  sent;
   int  nmsg;
   int  len;
   bit  close;

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // Reset configuration: one-, two- and three-byte messages at the byte extremes,
      // each ending with a closing newline after the short line.
      push_byte(8'h00, 1'b1);
      push_byte(8'hFF, 1'b0);
      push_byte(8'hFF, 1'b1);
      push_byte(8'h00, 1'b0);
      push_byte(8'h00, 1'b0);
      push_byte(8'h00, 1'b1);
      push_byte(8'hFF, 1'b0);
      push_byte(8'hFF, 1'b0);
      push_byte(8'hFF, 1'b1);
      push_byte(8'hFB, 1'b0);   // all four sextets give '+'
      push_byte(8'hEF, 1'b0);
      push_byte(8'hBE, 1'b1);
      settle();

      // One group per line: a newline after every group, never a doubled one at the end.
      // Write wrap enable with the upper data bits set; only bit zero counts.
      csr_write(CsrGroupsPerLine, 6'd1);
      csr_write(CsrWrapEnable, 6'b111111);
      push_run(6, 1'b1);
      push_byte(8'h5A, 1'b1);
      settle();

      // Wrapping off: no newlines at all, padding still applied.
      csr_write(CsrWrapEnable, 6'd0);
      push_run(4, 1'b1);
      settle();

      // Line length lowered mid-line: leave ten groups on a 63-group line, then drop the
      // length to four; the counter has to run round past 63 before it matches again.
      csr_write(CsrWrapEnable, 6'd1);
      csr_write(CsrGroupsPerLine, 6'd63);
      push_run(30, 1'b0);
      settle();
      csr_write(CsrGroupsPerLine, 6'd4);
      push_run(180, 1'b1);
      settle();
      sent = 210;

      // Zero groups per line: the line only breaks after 64 groups.
      csr_write(CsrGroupsPerLine, 6'd0);
      push_run(200, 1'b1);
      settle();
      sent += 200;

      // Random phases: new settings between phases, sometimes halfway through a message.
      while (sent < RandomBytes) begin
         req_calm = ($urandom_range(0, 3) == 0);
         rsp_calm = ($urandom_range(0, 3) == 0);
         if ($urandom_range(0, 3) != 0)
            csr_write(CsrWrapEnable, 6'($urandom_range(0, 63)));
         if ($urandom_range(0, 3) != 0) begin
            case ($urandom_range(0, 5))
               0:       csr_write(CsrGroupsPerLine, 6'd0);
               1:       csr_write(CsrGroupsPerLine, 6'd1);
               2:       csr_write(CsrGroupsPerLine, 6'd63);
               3:       csr_write(CsrGroupsPerLine, 6'($urandom_range(1, 4)));
               default: csr_write(CsrGroupsPerLine, 6'($urandom_range(0, 63)));
            endcase
         end
         nmsg = $urandom_range(1, 4);
         for (int m = 0; m < nmsg; m++) begin
            len   = ($urandom_range(0, 9) == 0) ? $urandom_range(90, 200)
                                                : $urandom_range(1, 20);
            // now and then leave the phase's final message open for the next setting
            close = (m != nmsg - 1) || ($urandom_range(0, 3) != 0);
            push_run(len, close);
            sent += len;
         end
         settle();
      end

      // Close whatever message is still open, then drain.
      req_calm = 1'b0;
      rsp_calm = 1'b0;
      push_byte(8'($urandom_range(0, 255)), 1'b1);
      settle();

      if (errors == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

endmodule

// ===== files.f =====
design/b64e_pkg.sv
design/b64e_front.sv
design/b64e_queue.sv
design/b64e_back.sv
design/base64_line_wrapped_encoder_top.sv
tb/tb.sv
